>>> rtl/sssd_pkg.sv
// Package for the seven-segment scan driver: shared types, constants and
// the digit-to-segment decode. No dependencies.
`default_nettype none

package sssd_pkg;

  localparam int POSITIONS = 4;

  typedef logic [3:0]  digit_t;
  typedef logic [1:0]  pos_t;
  typedef logic [2:0]  count_t;
  typedef logic [6:0]  seg_t;
  typedef logic [15:0] dwell_t;

  // Request codes on the action field
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic signed [15:0] VALUE_MIN = -16'sd999;
  localparam logic signed [15:0] VALUE_MAX = 16'sd9999;

  localparam dwell_t DWELL_RESET    = 16'd5;
  localparam seg_t   MINUS_SEGMENTS = 7'h40;

  // Segments a..g on bits 0..6, active high; non-decimal codes are blank
  function automatic seg_t seg_decode(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/seven_segment_scan_driver_core.sv
// Four-position multiplexed seven-segment scan driver, top level.
// Depends on sssd_pkg (types, constants, segment decode).
`default_nettype none

// Takes one request per clock when not stalled and gives one result per
// request, through an input register, then the result register. A load
// request clamps its value to -999..9999, splits the magnitude into decimal
// digits with three independent reciprocal multiplies, and answers blank;
// a tick request lights the current position and advances the dwell count.
// Back-pressure on the result side holds both stages; the input register
// still takes a request while a finished result waits, if it is empty.
module seven_segment_scan_driver_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_action,
  input  wire logic signed [15:0]    in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 out_digit_enable,
  output logic [6:0]                 out_segments,
  output logic [1:0]                 out_scan_slot,
  input  wire logic                  cfg_we,
  input  wire sssd_pkg::dwell_t      cfg_dwell_ticks
);
  import sssd_pkg::*;

  // input register
  logic               s1_valid_r;
  logic               s1_action_r;
  logic signed [15:0] s1_value_r;

  // display state
  dwell_t dwell_r;
  digit_t digits_r [POSITIONS];
  digit_t digits_nxt [POSITIONS];
  count_t count_r, count_nxt;
  logic   neg_r, neg_nxt;
  pos_t   scan_r, scan_nxt;
  dwell_t cnt_r, cnt_nxt;

  // result register
  logic   out_valid_r;
  logic [3:0] en_r, en_nxt;
  seg_t   seg_r, seg_nxt;
  pos_t   slot_r, slot_nxt;

  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  // ---- load path: clamp and decimal split
  logic signed [15:0] clamped;
  logic [15:0]        abs_v;
  logic [13:0]        mag;
  logic [29:0]        p10;
  logic [25:0]        p100;
  logic [26:0]        p1000;
  logic [9:0]         q1;
  logic [6:0]         q2;
  logic [3:0]         q3;
  logic [13:0]        r0;
  logic [9:0]         r1;
  logic [6:0]         r2;

  always_comb begin
    if (s1_value_r < VALUE_MIN) begin
      clamped = VALUE_MIN;
    end else if (s1_value_r > VALUE_MAX) begin
      clamped = VALUE_MAX;
    end else begin
      clamped = s1_value_r;
    end
    abs_v = clamped[15] ? 16'(-clamped) : 16'(clamped);
    mag   = abs_v[13:0];
    // floor(mag/10), /100, /1000, exact over 0..9999
    p10   = 30'(mag) * 30'd52429;
    p100  = 26'(mag) * 26'd5243;
    p1000 = 27'(mag) * 27'd8389;
    q1    = p10[28:19];
    q2    = p100[25:19];
    q3    = p1000[26:23];
    r0    = mag - 14'(q1) * 14'd10;
    r1    = q1 - 10'(q2) * 10'd10;
    r2    = q2 - 7'(q3) * 7'd10;
  end

  // ---- tick path
  logic [2:0] used;
  logic [2:0] pos_inc;
  dwell_t     dwell_eff;
  dwell_t     cnt_inc;

  always_comb begin
    used = count_r + {2'b00, neg_r};
    if (used == 3'd0) begin
      used = 3'd1;
    end else if (used > 3'(POSITIONS)) begin
      used = 3'(POSITIONS);
    end
    pos_inc   = {1'b0, scan_r} + 3'd1;
    dwell_eff = (dwell_r == '0) ? 16'd1 : dwell_r;
    cnt_inc   = cnt_r + 16'd1;
  end

  always_comb begin
    digits_nxt = digits_r;
    count_nxt  = count_r;
    neg_nxt    = neg_r;
    scan_nxt   = scan_r;
    cnt_nxt    = cnt_r;
    en_nxt     = '0;
    seg_nxt    = '0;
    slot_nxt   = '0;
    case (s1_action_r)
      ACT_LOAD: begin
        digits_nxt[0] = r0[3:0];
        digits_nxt[1] = r1[3:0];
        digits_nxt[2] = r2[3:0];
        digits_nxt[3] = q3;
        neg_nxt       = clamped[15];
        if (mag >= 14'd1000) begin
          count_nxt = 3'd4;
        end else if (mag >= 14'd100) begin
          count_nxt = 3'd3;
        end else if (mag >= 14'd10) begin
          count_nxt = 3'd2;
        end else begin
          count_nxt = 3'd1;
        end
        scan_nxt = '0;
        cnt_nxt  = '0;
      end
      ACT_TICK: begin
        en_nxt   = 4'(1) << scan_r;
        slot_nxt = scan_r;
        if ({1'b0, scan_r} < count_r) begin
          seg_nxt = seg_decode(digits_r[scan_r]);
        end else if (neg_r && ({1'b0, scan_r} == count_r)) begin
          seg_nxt = MINUS_SEGMENTS;
        end
        if (cnt_inc >= dwell_eff) begin
          cnt_nxt  = '0;
          scan_nxt = (pos_inc >= used) ? pos_t'(0) : pos_inc[1:0];
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dwell_r     <= DWELL_RESET;
      for (int i = 0; i < POSITIONS; i++) begin
        digits_r[i] <= '0;
      end
      count_r <= 3'd1;
      neg_r   <= 1'b0;
      scan_r  <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        dwell_r <= cfg_dwell_ticks;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          digits_r <= digits_nxt;
          count_r  <= count_nxt;
          neg_r    <= neg_nxt;
          scan_r   <= scan_nxt;
          cnt_r    <= cnt_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_action_r <= in_action;
      s1_value_r  <= in_value;
    end
    if (adv && s1_valid_r) begin
      en_r   <= en_nxt;
      seg_r  <= seg_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_enable = en_r;
  assign out_segments     = seg_r;
  assign out_scan_slot    = slot_r;

  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(en_r))
    else $error("more than one position lit");

  a_blank_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && en_r == 4'd0) |-> (seg_r == 7'd0 && slot_r == 2'd0))
    else $error("blank result carries segments or slot");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, scan_r} < used)
    else $error("scan position beyond used slots");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free stage");

endmodule

`default_nettype wire
